[rtl/pwbp_pkg.sv]
package pwbp_pkg;

  localparam int MAX_BLOCKS      = 1024;
  localparam int PRIORITY_LEVELS = 4;
  localparam int IDX_W           = 10;  // block index
  localparam int CNT_W           = 11;  // counts, sizes, register values
  localparam int PRIO_W          = 2;
  localparam int CFG_IDX_W       = 3;
  localparam int PROD_W          = 2 * CNT_W;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_GC    = 2'd2,
    ACT_INIT  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_WATERMARK    = 3'd1,
    ST_EXHAUSTED    = 3'd2,
    ST_NOT_IN_POOL  = 3'd3,
    ST_DOUBLE_FREE  = 3'd4,
    ST_GC_SKIPPED   = 3'd5,
    ST_INIT_REFUSED = 3'd6
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCKS_PER_CHUNK = 3'd0,
    CFG_MIN_CHUNKS       = 3'd1,
    CFG_MAX_CHUNKS       = 3'd2,
    CFG_MAX_BLOCKS       = 3'd3,
    CFG_WATERMARK_0      = 3'd4,
    CFG_WATERMARK_1      = 3'd5,
    CFG_WATERMARK_2      = 3'd6,
    CFG_WATERMARK_3      = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0]                      blocks_per_chunk;
    logic [CNT_W-1:0]                      min_chunks;
    logic [CNT_W-1:0]                      max_chunks;
    logic [CNT_W-1:0]                      max_blocks;
    logic [PRIORITY_LEVELS-1:0][CNT_W-1:0] watermark;
  } cfg_t;

  typedef struct packed {
    action_t           action;
    logic [PRIO_W-1:0] priority_req;
    logic [IDX_W-1:0]  block_index;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] granted_index;
    logic [CNT_W-1:0] pool_blocks;
    logic [CNT_W-1:0] free_blocks;
  } rsp_t;

endpackage

[rtl/priority_watermark_block_pool.sv]
// Block-index pool allocator with per-priority in-use watermarks. Takes one
// request per cycle (allocate, free, garbage collect, init) and returns one
// result per request; the result passes through the s1 register and the
// output register before it shows on out_tvalid, and requests stream back
// to back at one per cycle as long as out_tready stays high. That rate comes
// from the registered read of the free-queue RAM and the in-use flag RAM,
// both read as the request is accepted, with same-cycle writes forwarded.
// There is no clearing pass after reset: flags at or past the fresh-index
// point always read as free. The configuration port is always ready and
// should only be written while no request is in flight.
module priority_watermark_block_pool (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata:  [9:0] block_index, [15:10] zero
  // in_tuser:  [1:0] action, [3:2] priority_req
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic [3:0]  in_tuser,
  // out_tdata: [9:0] granted_index, [20:10] pool_blocks, [31:21] free_blocks
  // out_tuser: [2:0] status
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  output logic [2:0]  out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  pwbp_pkg::cfg_t cfg;
  pwbp_pkg::req_t req;
  pwbp_pkg::rsp_t rsp;

  assign req.action       = pwbp_pkg::action_t'(in_tuser[1:0]);
  assign req.priority_req = in_tuser[3:2];
  assign req.block_index  = in_tdata[9:0];

  assign out_tdata = {rsp.free_blocks, rsp.pool_blocks, rsp.granted_index};
  assign out_tuser = rsp.status;

  pwbp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pwbp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_req    (req),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_rsp   (rsp)
  );

endmodule

[rtl/pwbp_cfg.sv]
module pwbp_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pwbp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pwbp_pkg::CNT_W-1:0]       cfg_data,
  output pwbp_pkg::cfg_t                   cfg
);

  pwbp_pkg::cfg_t cfg_r;
  pwbp_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (pwbp_pkg::cfg_idx_t'(cfg_index))
        pwbp_pkg::CFG_BLOCKS_PER_CHUNK: cfg_nxt.blocks_per_chunk = cfg_data;
        pwbp_pkg::CFG_MIN_CHUNKS:       cfg_nxt.min_chunks       = cfg_data;
        pwbp_pkg::CFG_MAX_CHUNKS:       cfg_nxt.max_chunks       = cfg_data;
        pwbp_pkg::CFG_MAX_BLOCKS:       cfg_nxt.max_blocks       = cfg_data;
        pwbp_pkg::CFG_WATERMARK_0:      cfg_nxt.watermark[0]     = cfg_data;
        pwbp_pkg::CFG_WATERMARK_1:      cfg_nxt.watermark[1]     = cfg_data;
        pwbp_pkg::CFG_WATERMARK_2:      cfg_nxt.watermark[2]     = cfg_data;
        pwbp_pkg::CFG_WATERMARK_3:      cfg_nxt.watermark[3]     = cfg_data;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blocks_per_chunk <= pwbp_pkg::CNT_W'(64);
      cfg_r.min_chunks       <= pwbp_pkg::CNT_W'(1);
      cfg_r.max_chunks       <= pwbp_pkg::CNT_W'(16);
      cfg_r.max_blocks       <= pwbp_pkg::CNT_W'(pwbp_pkg::MAX_BLOCKS);
      for (int i = 0; i < pwbp_pkg::PRIORITY_LEVELS; i++) begin
        cfg_r.watermark[i] <= pwbp_pkg::CNT_W'(pwbp_pkg::MAX_BLOCKS);
      end
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[rtl/pwbp_ram.sv]
module pwbp_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_mem_r;
  logic [WIDTH-1:0] byp_data_r;
  logic             byp_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_mem_r   <= mem[raddr];
      byp_data_r <= wdata;
    end
  end

  // same-edge write to the read address: return the new data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (re) begin
      byp_r <= we && (waddr == raddr);
    end
  end

  assign rdata = byp_r ? byp_data_r : rd_mem_r;

endmodule

[rtl/pwbp_core.sv]
module pwbp_core (
  input  logic            clk,
  input  logic            rst_n,
  input  pwbp_pkg::cfg_t  cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  pwbp_pkg::req_t  in_req,
  output logic            out_valid,
  input  logic            out_ready,
  output pwbp_pkg::rsp_t  out_rsp
);

  localparam int IDX_W = pwbp_pkg::IDX_W;
  localparam int CNT_W = pwbp_pkg::CNT_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(pwbp_pkg::MAX_BLOCKS);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(pwbp_pkg::MAX_BLOCKS - 1);

  // handshake / stage control
  logic           s1_valid_r, s1_valid_nxt;
  pwbp_pkg::req_t s1_req_r;
  logic           out_valid_r, out_valid_nxt;
  pwbp_pkg::rsp_t out_rsp_r;
  logic           load, s1_fire;

  // pool state
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] qcnt_r, qcnt_nxt;
  logic [CNT_W-1:0] fresh_r, fresh_nxt;
  logic [CNT_W-1:0] pool_r, pool_nxt;
  logic [CNT_W-1:0] chunks_r, chunks_nxt;

  // memories
  logic             q_we, f_we, f_wdata;
  logic [IDX_W-1:0] q_waddr, q_wdata, q_raddr, q_rdata, f_waddr;
  logic             f_rdata;

  pwbp_pkg::rsp_t   rsp;

  assign s1_fire   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_fire;
  assign load      = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // head after the item in s1 commits
  assign q_raddr = s1_fire ? head_nxt : head_r;

  pwbp_ram #(.WIDTH(IDX_W), .DEPTH(pwbp_pkg::MAX_BLOCKS)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .re    (load),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  pwbp_ram #(.WIDTH(1), .DEPTH(pwbp_pkg::MAX_BLOCKS)) u_flags (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .re    (load),
    .raddr (in_req.block_index),
    .rdata (f_rdata)
  );

  always_comb begin
    logic [CNT_W-1:0]            in_use;
    logic [CNT_W:0]              ft_wide;
    logic [CNT_W-1:0]            ft;
    logic [CNT_W-1:0]            wm;
    logic [CNT_W-1:0]            rb_chunks;
    logic                        rb_short;
    logic [CNT_W-1:0]            mul_chunks;
    logic [pwbp_pkg::PROD_W-1:0] prod;
    logic [CNT_W-1:0]            size;
    logic                        flag;
    logic                        rebuild;
    logic [CNT_W:0]              ft_out;

    head_nxt   = head_r;
    tail_nxt   = tail_r;
    qcnt_nxt   = qcnt_r;
    fresh_nxt  = fresh_r;
    pool_nxt   = pool_r;
    chunks_nxt = chunks_r;
    q_we       = 1'b0;
    q_waddr    = tail_r;
    q_wdata    = s1_req_r.block_index;
    f_we       = 1'b0;
    f_waddr    = s1_req_r.block_index;
    f_wdata    = 1'b0;
    rebuild    = 1'b0;
    rsp.status        = pwbp_pkg::ST_OK;
    rsp.granted_index = '0;

    in_use  = fresh_r - qcnt_r;
    ft_wide = {1'b0, qcnt_r} + {1'b0, pool_r} - {1'b0, fresh_r};
    ft      = ft_wide[CNT_W-1:0];
    // priority field indexes exactly the four levels, no clamp needed
    wm      = cfg.watermark[s1_req_r.priority_req];

    rb_short  = cfg.min_chunks > cfg.max_chunks;
    rb_chunks = rb_short ? cfg.max_chunks : cfg.min_chunks;
    // growth never runs with chunks_r at the 11-bit top (chunks_r < max_chunks)
    mul_chunks = (s1_req_r.action == pwbp_pkg::ACT_ALLOC) ? chunks_r + CNT_W'(1) : rb_chunks;
    prod = {{CNT_W{1'b0}}, mul_chunks} * {{CNT_W{1'b0}}, cfg.blocks_per_chunk};
    size = (prod > pwbp_pkg::PROD_W'(pwbp_pkg::MAX_BLOCKS)) ? MAX_CNT : prod[CNT_W-1:0];

    // indices at or past the fresh point were never granted since the last
    // rebuild, so their flags are clear whatever the RAM holds
    flag = ({1'b0, s1_req_r.block_index} < fresh_r) && f_rdata;

    case (s1_req_r.action)
      pwbp_pkg::ACT_ALLOC: begin
        if (in_use > wm) begin
          rsp.status = pwbp_pkg::ST_WATERMARK;
        end else begin
          if (ft == '0) begin
            if (pool_r >= cfg.max_blocks || chunks_r >= cfg.max_chunks) begin
              rsp.status = pwbp_pkg::ST_EXHAUSTED;
            end else begin
              chunks_nxt = chunks_r + CNT_W'(1);
              if (size > pool_r) begin
                pool_nxt = size;
              end else begin
                rsp.status = pwbp_pkg::ST_EXHAUSTED;
              end
            end
          end
          if (rsp.status == pwbp_pkg::ST_OK) begin
            if (fresh_r < pool_nxt) begin
              rsp.granted_index = fresh_r[IDX_W-1:0];
              fresh_nxt = fresh_r + CNT_W'(1);
            end else begin
              rsp.granted_index = q_rdata;
              head_nxt = (head_r == LAST_SLOT) ? '0 : head_r + IDX_W'(1);
              qcnt_nxt = qcnt_r - CNT_W'(1);
            end
            f_we    = 1'b1;
            f_waddr = rsp.granted_index;
            f_wdata = 1'b1;
          end
        end
      end
      pwbp_pkg::ACT_FREE: begin
        if ({1'b0, s1_req_r.block_index} >= pool_r) begin
          rsp.status = pwbp_pkg::ST_NOT_IN_POOL;
        end else if (!flag || qcnt_r >= MAX_CNT) begin
          rsp.status = pwbp_pkg::ST_DOUBLE_FREE;
        end else begin
          f_we     = 1'b1;
          q_we     = 1'b1;
          tail_nxt = (tail_r == LAST_SLOT) ? '0 : tail_r + IDX_W'(1);
          qcnt_nxt = qcnt_r + CNT_W'(1);
        end
      end
      pwbp_pkg::ACT_GC: begin
        if (ft == pool_r && pool_r != cfg.blocks_per_chunk) begin
          rebuild = 1'b1;
        end else begin
          rsp.status = pwbp_pkg::ST_GC_SKIPPED;
        end
      end
      pwbp_pkg::ACT_INIT: begin
        if (ft != pool_r) begin
          rsp.status = pwbp_pkg::ST_INIT_REFUSED;
        end else begin
          rebuild = 1'b1;
          if (rb_short) begin
            rsp.status = pwbp_pkg::ST_EXHAUSTED;
          end
        end
      end
      default: rsp.status = pwbp_pkg::ST_OK;
    endcase

    // all blocks are free here, so every in-use flag is already clear
    if (rebuild) begin
      head_nxt   = '0;
      tail_nxt   = '0;
      qcnt_nxt   = '0;
      fresh_nxt  = '0;
      chunks_nxt = rb_chunks;
      pool_nxt   = size;
    end

    ft_out = {1'b0, qcnt_nxt} + {1'b0, pool_nxt} - {1'b0, fresh_nxt};
    rsp.pool_blocks = pool_nxt;
    rsp.free_blocks = ft_out[CNT_W-1:0];

    q_we = q_we && s1_fire;
    f_we = f_we && s1_fire;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      qcnt_r      <= '0;
      fresh_r     <= '0;
      pool_r      <= '0;
      chunks_r    <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        head_r   <= head_nxt;
        tail_r   <= tail_nxt;
        qcnt_r   <= qcnt_nxt;
        fresh_r  <= fresh_nxt;
        pool_r   <= pool_nxt;
        chunks_r <= chunks_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_req_r <= in_req;
    end
    if (s1_fire) begin
      out_rsp_r <= rsp;
    end
  end

  a_fresh_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r <= pool_r)
    else $error("fresh pointer beyond pool size");

  a_queue_le_granted: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= fresh_r)
    else $error("free queue holds more blocks than were handed out");

  a_grant_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_req_r.action == pwbp_pkg::ACT_ALLOC && rsp.status == pwbp_pkg::ST_OK)
      |-> ({1'b0, rsp.granted_index} < pool_nxt))
    else $error("granted index outside the pool");

  a_fire_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("completed item did not reach the output register");

endmodule
